>>> rtl/bdl_pkg.sv
package bdl_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int ITEM_W   = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD  = 3'd0,
        CMD_INS_TAIL  = 3'd1,
        CMD_REM_HEAD  = 3'd2,
        CMD_REM_TAIL  = 3'd3,
        CMD_READ_HEAD = 3'd4,
        CMD_READ_TAIL = 3'd5,
        CMD_READ_POS  = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

>>> rtl/bdl_ram.sv
module bdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/bounded_deque_list.sv
// bounded deque held as a ring buffer in one synchronous ram
//
// input channel: command, item_in, position with in_valid / in_stall. a word
// is taken when in_valid is high and in_stall is low. output channel:
// item_out, count, status with out_valid / out_stall, one word per command.
//
// inserts, removes, failed reads and the unused code finish in the accept
// cycle: the ram write and the head / count update happen at that edge and
// the result is shown the next cycle, so these run one command per cycle
// while out_stall is low. a read that finds its element issues the ram
// address at accept; the ram read register and then the output register
// carry its result, and in_stall holds off the next command until it lands.
//
// the output word sits in a register; a new command is taken while the
// receiver takes the previous word. while out_stall holds a word, in_stall
// is raised and nothing moves. reset empties the list (head and count go to
// zero) at once; the ram itself is not cleared, since only positions below
// the count are ever read and every one of them was written by an insert.
module bounded_deque_list #(
    parameter int DEPTH      = bdl_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = bdl_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bdl_pkg::CMD_W-1:0]     command,
    input  logic [bdl_pkg::ITEM_W-1:0]    item_in,
    input  logic [bdl_pkg::POS_W-1:0]     position,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bdl_pkg::ITEM_W-1:0]    item_out,
    output logic [bdl_pkg::COUNT_W-1:0]   count,
    output logic [bdl_pkg::STATUS_W-1:0]  status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int XW = (CW > bdl_pkg::POS_W) ? CW : bdl_pkg::POS_W;

    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic                      pend_reg;
    logic                      out_valid_reg;
    logic [bdl_pkg::ITEM_W-1:0] out_item_reg;
    bdl_pkg::status_t          out_status_reg;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      pos_bad;
    logic [AW-1:0]             head_dec;
    logic [AW-1:0]             head_inc;
    logic [SW-1:0]             offset;
    logic [SW-1:0]             slot_sum;
    logic [AW-1:0]             slot;
    logic                      cmd_we;
    logic                      cmd_re;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             raddr;
    logic [ELEM_WIDTH-1:0]     rd_data;
    bdl_pkg::status_t          cmd_status;

    assign accept   = in_valid && !in_stall;
    assign in_stall = pend_reg || (out_valid_reg && out_stall);

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_bad = (XW'(position) >= XW'(count_reg));

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // logical position to ram slot; offset stays below DEPTH where used
    always_comb
    begin
        unique case (bdl_pkg::cmd_t'(command))
            bdl_pkg::CMD_INS_TAIL:  offset = SW'(count_reg);
            bdl_pkg::CMD_READ_TAIL: offset = SW'(count_reg) - 1'b1;
            default:                offset = SW'(position);
        endcase
    end

    assign slot_sum = SW'(head_reg) + offset;
    assign slot     = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH))
                                               : AW'(slot_sum);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        cmd_we     = 1'b0;
        cmd_re     = 1'b0;
        waddr      = slot;
        raddr      = slot;
        cmd_status = bdl_pkg::ST_OK;
        unique case (bdl_pkg::cmd_t'(command))
            bdl_pkg::CMD_INS_HEAD:
            begin
                if (full)
                begin
                    cmd_status = bdl_pkg::ST_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    waddr      = head_dec;
                    cmd_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdl_pkg::CMD_INS_TAIL:
            begin
                if (full)
                begin
                    cmd_status = bdl_pkg::ST_FULL;
                end
                else
                begin
                    cmd_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdl_pkg::CMD_REM_HEAD:
            begin
                if (empty)
                begin
                    cmd_status = bdl_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            bdl_pkg::CMD_REM_TAIL:
            begin
                if (empty)
                begin
                    cmd_status = bdl_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            bdl_pkg::CMD_READ_HEAD:
            begin
                if (empty)
                begin
                    cmd_status = bdl_pkg::ST_EMPTY;
                end
                else
                begin
                    raddr  = head_reg;
                    cmd_re = 1'b1;
                end
            end
            bdl_pkg::CMD_READ_TAIL:
            begin
                if (empty)
                begin
                    cmd_status = bdl_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd_re = 1'b1;
                end
            end
            bdl_pkg::CMD_READ_POS:
            begin
                if (pos_bad)
                begin
                    cmd_status = bdl_pkg::ST_RANGE;
                end
                else
                begin
                    cmd_re = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // a write lands at the accept edge, so a read taken next cycle already
    // sees it; no forwarding is needed
    bdl_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept && cmd_we),
        .waddr (waddr),
        .wdata (ELEM_WIDTH'(item_in)),
        .re    (accept && cmd_re),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= cmd_re;
            out_valid_reg <= !cmd_re;
        end
        else if (pend_reg)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg   <= '0;
            out_status_reg <= cmd_status;
        end
        else if (pend_reg)
        begin
            out_item_reg <= bdl_pkg::ITEM_W'(rd_data);
        end
    end

    assign out_valid = out_valid_reg;
    assign item_out  = out_item_reg;
    // count only moves at accept, which coincides with the new output word
    assign count     = bdl_pkg::COUNT_W'(count_reg);
    assign status    = out_status_reg;

endmodule

>>> test/tb_bounded_deque_list.sv
`timescale 1ns / 1ps

import bdl_pkg::*;

typedef struct {
    logic [ITEM_W-1:0]  item;
    logic [COUNT_W-1:0] count;
    status_t            status;
} deque_word_t;

class deque_scoreboard;
    logic [ITEM_W-1:0] ring [DEPTH_DEF];
    int unsigned       head_slot;
    int unsigned       used;
    deque_word_t       expected_q[$];
    int                errors;
    int                noted;
    int                checked;
    int                full_drops;
    int                empty_hits;
    int                range_misses;
    int                peak_used;

    function new();
        head_slot    = 0;
        used         = 0;
        errors       = 0;
        noted        = 0;
        checked      = 0;
        full_drops   = 0;
        empty_hits   = 0;
        range_misses = 0;
        peak_used    = 0;
    endfunction

    function int unsigned slot(int unsigned p);
        return (head_slot + p) % DEPTH_DEF;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // run one accepted command word through the ring model
    function void note_command(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] item,
                               logic [POS_W-1:0] pos);
        deque_word_t w;
        w.item   = '0;
        w.status = ST_OK;
        case (cmd)
            CMD_INS_HEAD, CMD_INS_TAIL:
            begin
                if (used >= DEPTH_DEF)
                begin
                    w.status = ST_FULL;
                end
                else
                begin
                    if (cmd == CMD_INS_HEAD)
                    begin
                        head_slot       = (head_slot + DEPTH_DEF - 1) % DEPTH_DEF;
                        ring[head_slot] = item;
                    end
                    else
                    begin
                        ring[slot(used)] = item;
                    end
                    used++;
                end
            end
            CMD_REM_HEAD, CMD_REM_TAIL:
            begin
                if (used == 0)
                begin
                    w.status = ST_EMPTY;
                end
                else
                begin
                    if (cmd == CMD_REM_HEAD)
                        head_slot = slot(1);
                    used--;
                end
            end
            CMD_READ_HEAD, CMD_READ_TAIL:
            begin
                if (used == 0)
                    w.status = ST_EMPTY;
                else if (cmd == CMD_READ_HEAD)
                    w.item = ring[slot(0)];
                else
                    w.item = ring[slot(used - 1)];
            end
            CMD_READ_POS:
            begin
                if (pos >= used)
                    w.status = ST_RANGE;
                else
                    w.item = ring[slot(pos)];
            end
            default:
            begin
            end
        endcase
        w.count = COUNT_W'(used);
        if (w.status == ST_FULL)
            full_drops++;
        if (w.status == ST_EMPTY)
            empty_hits++;
        if (w.status == ST_RANGE)
            range_misses++;
        if (used > peak_used)
            peak_used = used;
        noted++;
        expected_q.push_back(w);
    endfunction

    function void check_word(logic [ITEM_W-1:0] item, logic [COUNT_W-1:0] cnt,
                             logic [STATUS_W-1:0] st);
        deque_word_t w;
        if (expected_q.size() == 0)
        begin
            $error("result word with nothing expected: item_out %h count %0d status %0d",
                   item, cnt, st);
            errors++;
            return;
        end
        w = expected_q.pop_front();
        checked++;
        if (item !== w.item)
        begin
            $error("item_out mismatch: expected %h, actual %h", w.item, item);
            errors++;
        end
        if (cnt !== w.count)
        begin
            $error("count mismatch: expected %0d, actual %0d", w.count, cnt);
            errors++;
        end
        if (st !== w.status)
        begin
            $error("status mismatch: expected %0d, actual %0d", w.status, st);
            errors++;
        end
    endfunction
endclass

module tb_bounded_deque_list;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int               LIMIT      = 300000;
    localparam int               HOLD_LEN   = 400;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    command;
    logic [ITEM_W-1:0]   item_in;
    logic [POS_W-1:0]    position;
    logic                out_valid;
    logic                out_stall;
    logic [ITEM_W-1:0]   item_out;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;

    deque_scoreboard sb;
    int              cycles = 0;
    // hold requests raised by the sender, served one by one by the receiver
    int              hold_reqs = 0;

    bounded_deque_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .item_in   (item_in),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .item_out  (item_out),
        .count     (count),
        .status    (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        sb = new();
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_command(command, item_in, position);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(item_out, count, status);
    end

    initial
    begin
        @(posedge clk);
        while (cycles < LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycles);
        $display("bounded_deque_list regression: fail");
        $finish;
    end

    // receiver: stall pattern changes per stretch, long hold on request
    initial
    begin
        int mode;
        int left;
        int hold_left;
        int holds_done;
        mode       = 0;
        left       = 0;
        hold_left  = 0;
        holds_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != hold_reqs)
            begin
                hold_left = HOLD_LEN;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] c, input logic [ITEM_W-1:0] d,
                             input logic [POS_W-1:0] p);
        in_valid <= 1'b1;
        command  <= c;
        item_in  <= d;
        position <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // bias 0 balanced, 1 toward growth, 2 toward shrinking
    task automatic send_random(input int bias);
        int               r;
        int               ins_pct;
        int               rem_pct;
        int               hi;
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;
        r       = $urandom_range(0, 99);
        ins_pct = (bias == 1) ? 55 : (bias == 2) ? 15 : 35;
        rem_pct = (bias == 1) ? 15 : (bias == 2) ? 55 : 35;
        p       = $urandom_range(0, 255);
        if (r == 0)
            c = CMD_UNUSED;
        else if (r < ins_pct)
            c = $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
        else if (r < ins_pct + rem_pct)
            c = $urandom_range(0, 1) ? CMD_REM_HEAD : CMD_REM_TAIL;
        else
        begin
            case ($urandom_range(0, 3))
                0:       c = CMD_READ_HEAD;
                1:       c = CMD_READ_TAIL;
                default: c = CMD_READ_POS;
            endcase
            // mostly positions near the filled range, some anywhere
            if ($urandom_range(0, 4) != 0)
            begin
                hi = (sb.used + 2 > 255) ? 255 : sb.used + 2;
                p  = $urandom_range(0, hi);
            end
        end
        send_word(c, $urandom, p);
    endtask

    task automatic send_series(input int n, input int bias, input bit gaps);
        int remaining;
        int blen;
        remaining = n;
        while (remaining > 0)
        begin
            blen = $urandom_range(1, 24);
            if (blen > remaining)
                blen = remaining;
            repeat (blen) send_random(bias);
            remaining -= blen;
            if (gaps && $urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int n;
        int guard;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        command  <= CMD_INS_HEAD;
        item_in  <= '0;
        position <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases
        send_word(CMD_REM_HEAD, 32'h0000_0000, 8'd0);
        send_word(CMD_REM_TAIL, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_HEAD, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_TAIL, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_POS, 32'h0000_0000, 8'd0);
        send_word(CMD_UNUSED, 32'hDEAD_BEEF, 8'hFF);
        // head insert wraps the ring pointer below slot zero
        send_word(CMD_INS_HEAD, 32'hFFFF_FFFF, 8'd0);
        send_word(CMD_INS_TAIL, 32'h0000_0000, 8'hFF);
        send_word(CMD_INS_HEAD, 32'h8000_0001, 8'd0);
        send_word(CMD_READ_HEAD, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_TAIL, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_POS, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_POS, 32'h0000_0000, 8'd1);
        send_word(CMD_READ_POS, 32'h0000_0000, 8'd2);
        send_word(CMD_READ_POS, 32'h0000_0000, 8'd3);
        send_word(CMD_READ_POS, 32'h0000_0000, 8'd255);
        send_word(CMD_UNUSED, 32'h1234_5678, 8'd1);
        send_word(CMD_REM_HEAD, 32'h0000_0000, 8'd0);
        send_word(CMD_REM_TAIL, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_HEAD, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_TAIL, 32'h0000_0000, 8'd0);

        send_series(150, 0, 1'b1);

        // long receiver hold while words keep coming
        @(negedge clk);
        hold_reqs++;
        @(posedge clk);
        send_series(40, 1, 1'b0);

        send_series(100, 1, 1'b1);

        // fill to the top from a known count, then push against full
        wait_drained();
        n = DEPTH_DEF - sb.used;
        while (n > 0)
        begin
            send_word($urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL, $urandom, 8'd0);
            n--;
            if ($urandom_range(0, 15) == 0)
                idle_cycles($urandom_range(1, 6));
        end
        send_word(CMD_INS_HEAD, $urandom, 8'd0);
        send_word(CMD_INS_TAIL, $urandom, 8'd0);
        send_word(CMD_READ_POS, 32'h0000_0000, 8'd255);
        send_word(CMD_READ_POS, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_HEAD, 32'h0000_0000, 8'd0);
        send_word(CMD_READ_TAIL, 32'h0000_0000, 8'd0);

        send_series(150, 2, 1'b1);

        in_valid <= 1'b0;
        guard = 0;
        @(negedge clk);
        while (sb.pending() != 0 && guard < 10000)
        begin
            guard++;
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end

        $display("checked %0d result words from %0d commands in %0d cycles, peak count %0d",
                 sb.checked, sb.noted, cycles, sb.peak_used);
        $display("inserts dropped on full %0d, empty hits %0d, out of range reads %0d",
                 sb.full_drops, sb.empty_hits, sb.range_misses);
        if (sb.errors == 0)
            $display("bounded_deque_list regression: pass");
        else
            $display("bounded_deque_list regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/bdl_pkg.sv
rtl/bdl_ram.sv
rtl/bounded_deque_list.sv
test/tb_bounded_deque_list.sv
